[rtl/amou_pkg.sv]
// shared codes, widths and defaults for the atomic memory operation unit
`default_nettype none

package amou_pkg;

  localparam int OP_W     = 4;
  localparam int SIZE_W   = 2;
  localparam int ADDR_W   = 13;
  localparam int DATA_W   = 64;
  localparam int STATUS_W = 2;

  // word address carried by a byte address
  localparam int WADDR_W = ADDR_W - 3;

  localparam int STORE_WORDS_DEF = 1024;

  // input beat: operation, access_size, byte_address, source_value,
  // desired_high, compare_low, compare_high, zero padded to whole bytes
  localparam int IN_FIELDS_W = OP_W + SIZE_W + ADDR_W + 4 * DATA_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

  // result beat: old_low, old_high, status, zero padded to whole bytes
  localparam int OUT_FIELDS_W = 2 * DATA_W + STATUS_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [OP_W-1:0] OP_LOAD  = 4'd0;
  localparam logic [OP_W-1:0] OP_STORE = 4'd1;
  localparam logic [OP_W-1:0] OP_ADD   = 4'd2;
  localparam logic [OP_W-1:0] OP_CLEAR = 4'd3;
  localparam logic [OP_W-1:0] OP_XOR   = 4'd4;
  localparam logic [OP_W-1:0] OP_SET   = 4'd5;
  localparam logic [OP_W-1:0] OP_SMAX  = 4'd6;
  localparam logic [OP_W-1:0] OP_SMIN  = 4'd7;
  localparam logic [OP_W-1:0] OP_UMAX  = 4'd8;
  localparam logic [OP_W-1:0] OP_UMIN  = 4'd9;
  localparam logic [OP_W-1:0] OP_SWAP  = 4'd10;
  localparam logic [OP_W-1:0] OP_CAS   = 4'd11;
  localparam logic [OP_W-1:0] OP_CASP  = 4'd12;

  localparam logic [SIZE_W-1:0] SIZE_B = 2'd0;
  localparam logic [SIZE_W-1:0] SIZE_H = 2'd1;
  localparam logic [SIZE_W-1:0] SIZE_W32 = 2'd2;
  localparam logic [SIZE_W-1:0] SIZE_D = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISALIGN = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd2;

  function automatic logic [DATA_W-1:0] size_mask(input logic [SIZE_W-1:0] sz);
    logic [DATA_W-1:0] m;
    case (sz)
      SIZE_B:   m = 64'h0000_0000_0000_00ff;
      SIZE_H:   m = 64'h0000_0000_0000_ffff;
      SIZE_W32: m = 64'h0000_0000_ffff_ffff;
      default:  m = 64'hffff_ffff_ffff_ffff;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

[rtl/atomic_memory_op_unit.sv]
// atomic memory operation unit: load, store, read-modify-write, cas and casp on a word store
//
// usage: requests arrive as beats on the in_ channel (tvalid/tready/tdata), one request
// per beat; each request gives exactly one result beat on the out_ channel carrying the
// old value(s) and a status code. the store holds STORE_WORDS little-endian 64-bit words.
// sequencing: a request is taken only while the unit is idle. every request first registers
// its word index (by a reciprocal reduction); an error request (bad opcode, bad size or
// misaligned address) then goes straight to its result. a normal request reads its word
// from the store (a registered read) and, unless it is a load, writes it back; an
// 8-byte-half casp reads a second word first, and a casp that writes both words needs a
// second write step, as the store has a single write port. the next request is taken the
// cycle after the result is handed to the output register, and not before.
// reset: rst_n low clears control state; afterwards the unit sweeps the store, writing zero
// to one word per cycle through all STORE_WORDS words, and accepts no request until done.
// stall: the result sits in an output register; while the receiver holds out_tready low
// a new request can still be taken and worked on, and it waits before its hand-off until
// the output register is free.
`default_nettype none

module atomic_memory_op_unit
  import amou_pkg::*;
#(
  parameter int STORE_WORDS = STORE_WORDS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // operation[3:0], access_size[5:4], byte_address[18:6], source_value[82:19],
  // desired_high[146:83], compare_low[210:147], compare_high[274:211], zero pad above
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // old_low[63:0], old_high[127:64], status[129:128], zero pad above
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  localparam int WIDX_W  = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int RECIP_K = 20;
  localparam int RECIP_W = RECIP_K + 1;
  localparam int PROD_W  = RECIP_W + WADDR_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_K) / STORE_WORDS);
  localparam logic [RECIP_W-1:0] NWORDS = RECIP_W'(STORE_WORDS);
  localparam logic [WIDX_W-1:0]  LAST_IDX = WIDX_W'(STORE_WORDS - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_IDX   = 3'd2;
  localparam logic [2:0] S_RD2   = 3'd3;
  localparam logic [2:0] S_MOD   = 3'd4;
  localparam logic [2:0] S_WR2   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [DATA_W-1:0] mem [STORE_WORDS];

  logic [2:0]          state_r, state_nxt;
  logic [WIDX_W-1:0]   clr_cnt_r;
  logic                out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic [OP_W-1:0]     op_r;
  logic [SIZE_W-1:0]   size_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [DATA_W-1:0]   src_r, dhi_r, clo_r, chi_r;
  logic [WADDR_W-1:0]  quot_r;
  logic [WIDX_W-1:0]   widx_r, widx2_r;
  logic [DATA_W-1:0]   rd_q_r, lo_r;
  logic [DATA_W-1:0]   res_lo_r, res_hi_r;
  logic [STATUS_W-1:0] res_st_r;

  logic                in_accept;
  logic [PROD_W-1:0]   quot_prod;
  logic [PROD_W-1:0]   back_prod;
  logic [WADDR_W-1:0]  rem_est;
  logic [RECIP_W-1:0]  rem_wide;
  logic [WIDX_W-1:0]   widx;

  logic                bad_op, misaligned;
  logic [3:0]          align_mask;

  logic                rd_en;
  logic [WIDX_W-1:0]   rd_addr;
  logic                mem_we;
  logic [WIDX_W-1:0]   mem_waddr;
  logic [DATA_W-1:0]   mem_wdata;

  logic [DATA_W-1:0]   mask, sign, old_v, src_m, cmp_m, new_v, merged;
  logic [5:0]          shift;
  logic [DATA_W-1:0]   pair_lo, pair_hi;
  logic                pair_eq;
  logic [DATA_W-1:0]   mod_lo, mod_hi;
  logic                mod_we, mod_wr2;
  logic [DATA_W-1:0]   mod_wdata;

  assign in_tready  = (state_r == S_IDLE);
  assign in_accept  = in_tvalid & in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // word index = (byte_address / 8) mod STORE_WORDS by reciprocal, corrected once
  assign quot_prod = PROD_W'(in_tdata[18:9]) * PROD_W'(RECIP);
  assign back_prod = PROD_W'(quot_r) * PROD_W'(NWORDS);
  assign rem_est   = addr_r[ADDR_W-1:3] - back_prod[WADDR_W-1:0];
  always_comb begin
    rem_wide = RECIP_W'(rem_est);
    if (rem_wide >= NWORDS) begin
      rem_wide = rem_wide - NWORDS;
    end
  end
  assign widx = rem_wide[WIDX_W-1:0];

  // request checks
  assign bad_op = (op_r > OP_CASP) || ((op_r == OP_CASP) && (size_r < SIZE_W32));
  always_comb begin
    if (op_r == OP_CASP) begin
      align_mask = (size_r == SIZE_D) ? 4'hf : 4'h7;
    end else begin
      case (size_r)
        SIZE_B:   align_mask = 4'h0;
        SIZE_H:   align_mask = 4'h1;
        SIZE_W32: align_mask = 4'h3;
        default:  align_mask = 4'h7;
      endcase
    end
  end
  assign misaligned = (addr_r[3:0] & align_mask) != 4'h0;

  // modify path
  assign mask  = size_mask(size_r);
  assign sign  = (mask >> 1) + 64'd1;
  assign shift = {addr_r[2:0], 3'b000};
  assign old_v = (rd_q_r >> shift) & mask;
  assign src_m = src_r & mask;
  assign cmp_m = clo_r & mask;

  always_comb begin
    case (op_r)
      OP_STORE: new_v = src_m;
      OP_ADD:   new_v = old_v + src_m;
      OP_CLEAR: new_v = old_v & ~src_m;
      OP_XOR:   new_v = old_v ^ src_m;
      OP_SET:   new_v = old_v | src_m;
      OP_SMAX:  new_v = ((src_m ^ sign) < (old_v ^ sign)) ? old_v : src_m;
      OP_SMIN:  new_v = ((old_v ^ sign) < (src_m ^ sign)) ? old_v : src_m;
      OP_UMAX:  new_v = (src_m < old_v) ? old_v : src_m;
      OP_UMIN:  new_v = (old_v < src_m) ? old_v : src_m;
      OP_SWAP:  new_v = src_m;
      OP_CAS:   new_v = (old_v == cmp_m) ? src_m : old_v;
      default:  new_v = old_v;
    endcase
  end
  assign merged = (rd_q_r & ~(mask << shift)) | ((new_v & mask) << shift);

  // casp: 8-byte halves span two words, 4-byte halves share one word
  always_comb begin
    if (size_r == SIZE_D) begin
      pair_lo = lo_r;
      pair_hi = rd_q_r;
      pair_eq = (lo_r == clo_r) && (rd_q_r == chi_r);
    end else begin
      pair_lo = rd_q_r & mask;
      pair_hi = (rd_q_r >> 32) & mask;
      pair_eq = (pair_lo == (clo_r & mask)) && (pair_hi == (chi_r & mask));
    end
  end

  always_comb begin
    if (op_r == OP_CASP) begin
      mod_lo    = pair_lo;
      mod_hi    = pair_hi;
      mod_we    = pair_eq;
      mod_wr2   = pair_eq && (size_r == SIZE_D);
      mod_wdata = (size_r == SIZE_D) ? src_r : {dhi_r[31:0], src_r[31:0]};
    end else begin
      mod_lo    = (op_r == OP_STORE) ? '0 : old_v;
      mod_hi    = '0;
      mod_we    = (op_r != OP_LOAD);
      mod_wr2   = 1'b0;
      mod_wdata = merged;
    end
  end

  // sequencer and memory port control
  always_comb begin
    state_nxt = state_r;
    rd_en     = 1'b0;
    rd_addr   = widx;
    mem_we    = 1'b0;
    mem_waddr = widx_r;
    mem_wdata = mod_wdata;
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = '0;
        if (clr_cnt_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_IDX;
        end
      end
      S_IDX: begin
        if (bad_op || misaligned) begin
          state_nxt = S_DONE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = widx;
          state_nxt = ((op_r == OP_CASP) && (size_r == SIZE_D)) ? S_RD2 : S_MOD;
        end
      end
      S_RD2: begin
        rd_en     = 1'b1;
        rd_addr   = widx2_r;
        state_nxt = S_MOD;
      end
      S_MOD: begin
        mem_we    = mod_we;
        mem_waddr = widx_r;
        mem_wdata = mod_wdata;
        state_nxt = mod_wr2 ? S_WR2 : S_DONE;
      end
      S_WR2: begin
        mem_we    = 1'b1;
        mem_waddr = widx2_r;
        mem_wdata = dhi_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r   <= in_tdata[3:0];
      size_r <= in_tdata[5:4];
      addr_r <= in_tdata[18:6];
      src_r  <= in_tdata[82:19];
      dhi_r  <= in_tdata[146:83];
      clo_r  <= in_tdata[210:147];
      chi_r  <= in_tdata[274:211];
      quot_r <= quot_prod[RECIP_K +: WADDR_W];
    end
    if (state_r == S_IDX) begin
      widx_r   <= widx;
      widx2_r  <= (widx == LAST_IDX) ? '0 : widx + 1'b1;
      res_lo_r <= '0;
      res_hi_r <= '0;
      res_st_r <= bad_op ? ST_INVALID : (misaligned ? ST_MISALIGN : ST_DONE);
    end
    if (state_r == S_RD2) begin
      lo_r <= rd_q_r;
    end
    if (state_r == S_MOD) begin
      res_lo_r <= mod_lo;
      res_hi_r <= mod_hi;
    end
    if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
      out_data_r <= OUT_TDATA_W'({res_st_r, res_hi_r, res_lo_r});
    end
  end

endmodule

`default_nettype wire

[test/atomic_memory_op_unit_tb.sv]
// self-checking testbench for the atomic memory operation unit
module atomic_memory_op_unit_tb;
  import amou_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_WORDS = STORE_WORDS_DEF;
  localparam int RANDOM_REQUESTS = 950;
  localparam int CYCLE_LIMIT = 400000;
  localparam int IDLE_PERCENT = 11;

  typedef struct packed {
    logic              drain;
    logic [DATA_W-1:0] chi;
    logic [DATA_W-1:0] clo;
    logic [DATA_W-1:0] dhi;
    logic [DATA_W-1:0] src;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
    logic [OP_W-1:0]   op;
  } amo_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   old_hi;
    logic [DATA_W-1:0]   old_lo;
  } amo_resp_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // [0] tracks the store as requests are generated, [1] as they are accepted
  logic [DATA_W-1:0] store_model [2][STORE_WORDS];

  amo_req_t  pending_requests[$];
  amo_resp_t expected_results[$];
  amo_req_t  cur_req;
  logic      in_hs = 1'b0;
  int        requests_seen = 0;
  int        results_seen = 0;
  int        error_count = 0;
  int        cycle_count = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;

  atomic_memory_op_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  function automatic logic [DATA_W-1:0] width_bits(input logic [SIZE_W-1:0] sz);
    if (sz == SIZE_D) begin
      return '1;
    end
    return (64'd1 << (8 << sz)) - 64'd1;
  endfunction

  function automatic bit signed_below(input logic [DATA_W-1:0] a, b, m);
    logic [DATA_W-1:0] sign;
    sign = m ^ (m >> 1);
    return (a ^ sign) < (b ^ sign);
  endfunction

  // applies one request to the chosen store copy and returns its result
  function automatic amo_resp_t run_request(input int copy, input amo_req_t r);
    amo_resp_t res;
    logic [DATA_W-1:0] m, w, old, src, cmp, nv, lo, hi;
    int bytes, total, widx, widx2, shift;
    res = '0;
    bytes = 1 << r.size;
    total = (r.op == OP_CASP) ? 2 * bytes : bytes;
    m = width_bits(r.size);
    widx = (r.addr >> 3) % STORE_WORDS;
    shift = 8 * r.addr[2:0];
    if (r.op > OP_CASP || (r.op == OP_CASP && r.size < SIZE_W32)) begin
      res.status = ST_INVALID;
    end else if ((r.addr & (total - 1)) != 0) begin
      res.status = ST_MISALIGN;
    end else if (r.op == OP_CASP) begin
      if (r.size == SIZE_D) begin
        widx2 = (widx + 1) % STORE_WORDS;
        lo = store_model[copy][widx];
        hi = store_model[copy][widx2];
        if (lo == r.clo && hi == r.chi) begin
          store_model[copy][widx] = r.src;
          store_model[copy][widx2] = r.dhi;
        end
      end else begin
        w = store_model[copy][widx];
        lo = w & m;
        hi = (w >> 32) & m;
        if (lo == (r.clo & m) && hi == (r.chi & m)) begin
          store_model[copy][widx] = ((r.dhi & m) << 32) | (r.src & m);
        end
      end
      res.old_lo = lo;
      res.old_hi = hi;
      res.status = ST_DONE;
    end else begin
      w = store_model[copy][widx];
      old = (w >> shift) & m;
      src = r.src & m;
      cmp = r.clo & m;
      case (r.op)
        OP_STORE, OP_SWAP: nv = src;
        OP_ADD:   nv = old + src;
        OP_CLEAR: nv = old & ~src;
        OP_XOR:   nv = old ^ src;
        OP_SET:   nv = old | src;
        OP_SMAX:  nv = signed_below(src, old, m) ? old : src;
        OP_SMIN:  nv = signed_below(old, src, m) ? old : src;
        OP_UMAX:  nv = (src < old) ? old : src;
        OP_UMIN:  nv = (old < src) ? old : src;
        OP_CAS:   nv = (old == cmp) ? src : old;
        default:  nv = old;
      endcase
      nv = nv & m;
      store_model[copy][widx] = (w & ~(m << shift)) | (nv << shift);
      res.old_lo = (r.op == OP_STORE) ? '0 : old;
      res.status = ST_DONE;
    end
    return res;
  endfunction

  // value at an address as the generator sees it, for compares that hit
  function automatic logic [DATA_W-1:0] current_value(input logic [ADDR_W-1:0] a,
                                                       input logic [SIZE_W-1:0] sz);
    return (store_model[0][(a >> 3) % STORE_WORDS] >> (8 * a[2:0])) & width_bits(sz);
  endfunction

  function automatic logic [DATA_W-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000 >> (8 * $urandom_range(0, 7));
      3: return 64'h7fff_ffff_ffff_ffff >> (8 * $urandom_range(0, 7));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic void add_req(input logic [OP_W-1:0] op, input logic [SIZE_W-1:0] sz,
                                  input logic [ADDR_W-1:0] a,
                                  input logic [DATA_W-1:0] src, dhi, clo, chi,
                                  input logic drain);
    amo_req_t r;
    r.op = op;
    r.size = sz;
    r.addr = a;
    r.src = src;
    r.dhi = dhi;
    r.clo = clo;
    r.chi = chi;
    r.drain = drain;
    void'(run_request(0, r));
    pending_requests.push_back(r);
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    int i, n, k, tl;
    logic [OP_W-1:0] op;
    logic [SIZE_W-1:0] sz;
    logic [ADDR_W-1:0] a;
    logic [DATA_W-1:0] src, dhi, clo, chi, m;
    for (i = 0; i < STORE_WORDS; i++) begin
      store_model[0][i] = '0;
      store_model[1][i] = '0;
    end

    // directed: every operation, width extremes, truncation, errors
    add_req(OP_STORE, SIZE_D, 0, '1, '0, '0, '0, 1'b0);
    add_req(OP_LOAD, SIZE_D, 0, '0, '0, '0, '0, 1'b0);
    add_req(OP_ADD, SIZE_B, 0, 64'h1, '0, '0, '0, 1'b0);
    add_req(OP_LOAD, SIZE_D, 0, '1, '1, '1, '1, 1'b0);
    add_req(OP_STORE, SIZE_H, 8, 64'hffff_ffff_ffff_8000, '0, '0, '0, 1'b0);
    add_req(OP_SMAX, SIZE_H, 8, 64'h7fff, '0, '0, '0, 1'b0);
    add_req(OP_SMIN, SIZE_H, 8, 64'h8000, '0, '0, '0, 1'b0);
    add_req(OP_UMAX, SIZE_W32, 16, 64'hffff_ffff, '0, '0, '0, 1'b0);
    add_req(OP_UMIN, SIZE_W32, 16, 64'h0, '0, '0, '0, 1'b0);
    add_req(OP_CLEAR, SIZE_D, 0, 64'h00ff_00ff_00ff_00ff, '0, '0, '0, 1'b0);
    add_req(OP_XOR, SIZE_B, 7, 64'haa, '0, '0, '0, 1'b0);
    add_req(OP_SET, SIZE_H, 2, 64'h1234, '0, '0, '0, 1'b0);
    add_req(OP_SWAP, SIZE_D, 8184, 64'h0123_4567_89ab_cdef, '0, '0, '0, 1'b0);
    add_req(OP_CAS, SIZE_D, 8184, '1, '0, current_value(8184, SIZE_D), '0, 1'b0);
    add_req(OP_CAS, SIZE_D, 8184, '0, '0, 64'h5, '0, 1'b0);
    add_req(OP_CASP, SIZE_W32, 24, 64'hdead_beef, 64'hcafe_f00d, '0, '0, 1'b0);
    add_req(OP_CASP, SIZE_D, 32, '1, 64'h8000_0000_0000_0000, '0, '0, 1'b0);
    add_req(OP_CASP, SIZE_D, 32, '0, '0, '1, '0, 1'b0);
    add_req(OP_CASP, SIZE_D, 8176, 64'h1, 64'h2, current_value(8176, SIZE_D),
            current_value(8184, SIZE_D), 1'b0);
    add_req(OP_W'(OP_CASP + 1), SIZE_D, 0, '1, '1, '1, '1, 1'b0);
    add_req('1, SIZE_B, 1, '1, '1, '1, '1, 1'b0);
    add_req(OP_CASP, SIZE_B, 0, '1, '1, '0, '0, 1'b0);
    add_req(OP_CASP, SIZE_H, 1, '1, '1, '0, '0, 1'b0);
    add_req(OP_LOAD, SIZE_H, 1, '0, '0, '0, '0, 1'b0);
    add_req(OP_STORE, SIZE_D, 4, '1, '0, '0, '0, 1'b0);
    add_req(OP_CASP, SIZE_D, 8, '1, '1, '0, '0, 1'b0);
    add_req(OP_CASP, SIZE_W32, 4, '1, '1, '0, '0, 1'b0);
    add_req(OP_LOAD, SIZE_B, 8191, '0, '0, '0, '0, 1'b0);

    // random: mostly aligned accesses to a few hot words so operations chain
    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      k = $urandom_range(0, 99);
      if (k < 4) begin
        op = OP_W'($urandom_range(OP_CASP + 1, (1 << OP_W) - 1));
      end else begin
        op = OP_W'($urandom_range(0, OP_CASP));
      end
      sz = SIZE_W'($urandom_range(0, 3));
      tl = (op == OP_CASP) ? sz + 1 : sz;
      k = $urandom_range(0, 99);
      a = ADDR_W'((k < 80) ? $urandom_range(0, 127) : $urandom_range(0, (1 << ADDR_W) - 1));
      if (k < 94) begin
        a = a & ~ADDR_W'((1 << tl) - 1);
      end
      src = pick_operand();
      dhi = pick_operand();
      clo = pick_operand();
      chi = pick_operand();
      // most compares hit, with junk above the access width
      if ($urandom_range(0, 99) < 60) begin
        m = width_bits(sz);
        clo = (clo & ~m) | current_value(a, sz);
        if (op == OP_CASP) begin
          chi = (chi & ~m) | current_value(ADDR_W'(a + (1 << sz)), sz);
          if ($urandom_range(0, 3) == 0) begin
            chi = chi ^ 64'h1;
          end
        end
      end
      add_req(op, sz, a, src, dhi, clo, chi, n == 200 || n == 800);
    end

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    while (pending_requests.size() != 0 || in_tvalid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (40) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // request driver
  always @(negedge clk) begin : drive_requests
    amo_req_t r;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_hs) begin
      if (pending_requests.size() == 0 ||
          (pending_requests[0].drain && expected_results.size() != 0) ||
          (!(requests_seen >= 500 && requests_seen < 700) &&
           $urandom_range(0, 99) < IDLE_PERCENT)) begin
        in_tvalid <= 1'b0;
      end else begin
        r = pending_requests.pop_front();
        cur_req <= r;
        in_tvalid <= 1'b1;
        in_tdata <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, r.chi, r.clo, r.dhi, r.src,
                     r.addr, r.size, r.op};
      end
    end
  end

  // result receiver with one long hold-off so the unit backs up
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= 300) begin
      out_tready <= 1'b0;
      hold_left <= 400;
      hold_done <= 1'b1;
    end else begin
      out_tready <= (results_seen >= 500 && results_seen < 700) ||
                    $urandom_range(0, 99) >= IDLE_PERCENT;
    end
  end

  // predict on each accepted request beat, check each result beat
  always @(posedge clk) begin : check_results
    amo_resp_t want;
    if (!rst_n) begin
      in_hs <= 1'b0;
    end else begin
      in_hs <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        expected_results.push_back(run_request(1, cur_req));
        requests_seen++;
      end
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          if (error_count < 10) begin
            $display("result %0d: unexpected beat lo %h hi %h status %0d", results_seen,
                     out_tdata[63:0], out_tdata[127:64], out_tdata[129:128]);
          end
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_tdata[63:0] !== want.old_lo || out_tdata[127:64] !== want.old_hi ||
              out_tdata[129:128] !== want.status) begin
            if (error_count < 10) begin
              $display("result %0d: expected lo %h hi %h status %0d, got lo %h hi %h status %0d",
                       results_seen, want.old_lo, want.old_hi, want.status,
                       out_tdata[63:0], out_tdata[127:64], out_tdata[129:128]);
            end
            error_count++;
          end
        end
        results_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule
